[design/iee_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Infix evaluator package
// Operator codes, status codes, stack sizes and small helpers.
// ---------------------------------------------------------------------------
package iee_pkg;
	localparam int OpDepth  = 32;
	localparam int ValDepth = 32;
	localparam int OpAw     = $clog2(OpDepth);
	localparam int ValAw    = $clog2(ValDepth);
	localparam int OpCw     = $clog2(OpDepth + 1);
	localparam int ValCw    = $clog2(ValDepth + 1);

	localparam logic [2:0] OPC_PAREN = 3'd0;
	localparam logic [2:0] OPC_ADD   = 3'd1;
	localparam logic [2:0] OPC_SUB   = 3'd2;
	localparam logic [2:0] OPC_MUL   = 3'd3;
	localparam logic [2:0] OPC_DIV   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_DIVZERO   = 2'd2;
	localparam logic [1:0] ST_OVERFLOW  = 2'd3;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MUL    = 8'h2a;
	localparam logic [7:0] CH_ADD    = 8'h2b;
	localparam logic [7:0] CH_SUB    = 8'h2d;
	localparam logic [7:0] CH_DIV    = 8'h2f;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Request to and answer from the shared arithmetic unit.
	typedef struct packed {
		logic        start;
		logic [2:0]  op;
		logic [31:0] lhs;
		logic [31:0] rhs;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic        divzero;
		logic [31:0] res;
	} alu_rsp_t;

	function automatic logic prec_hi(input logic [2:0] op);
		return (op == OPC_MUL) || (op == OPC_DIV);
	endfunction
endpackage

[design/iee_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module iee_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[design/iee_alu.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared arithmetic unit
// Add, subtract and multiply with a registered result; signed divide one bit a cycle.
// ---------------------------------------------------------------------------
module iee_alu import iee_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic        neg_q;
	logic        done_q;
	logic        dz_q;
	logic [31:0] res_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;
	logic [31:0] mag_l;
	logic [31:0] mag_r;

	assign mag_l  = req.lhs[31] ? (~req.lhs + 32'd1) : req.lhs;
	assign mag_r  = req.rhs[31] ? (~req.rhs + 32'd1) : req.rhs;
	assign rem_sh = {rem_q[30:0], quo_q[31]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				dz_q <= 1'b0;
				case (req.op)
					OPC_ADD: begin
						res_q  <= req.lhs + req.rhs;
						done_q <= 1'b1;
					end
					OPC_SUB: begin
						res_q  <= req.lhs - req.rhs;
						done_q <= 1'b1;
					end
					OPC_MUL: begin
						res_q  <= req.lhs * req.rhs;
						done_q <= 1'b1;
					end
					default: begin
						if (req.rhs == 32'd0) begin
							dz_q   <= 1'b1;
							done_q <= 1'b1;
						end else begin
							busy_q <= 1'b1;
							cnt_q  <= 6'd32;
							quo_q  <= mag_l;
							rem_q  <= '0;
							dsr_q  <= mag_r;
							neg_q  <= req.lhs[31] ^ req.rhs[31];
						end
					end
				endcase
			end else if (busy_q) begin
				// Restoring division: one quotient bit per cycle.
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
			if (busy_q && cnt_q == 6'd1) begin
				res_q  <= neg_q ? ~({quo_q[30:0], !trial[32]}) + 32'd1
				                : {quo_q[30:0], !trial[32]};
				done_q <= 1'b1;
			end
		end
	end

	assign rsp.done    = done_q;
	assign rsp.divzero = dz_q;
	assign rsp.res     = res_q;
endmodule

[design/infix_expression_evaluator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Infix expression evaluator
// Shunting-yard evaluation with operator and value stacks in RAM.
// ---------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid, in_ready, char_code, last_char
// out     | output    | out_valid, out_ready, value, status
// A digit, '(' or ignored character is handled in S_DEC; an operator or ')'
// goes on through S_OPRD and S_OPCHK, and each operator popped through S_V1
// to S_ALU, where a divide waits on the shared unit. The final drain pops
// operators the same way; the result is then offered and waits for out_ready.
// Reset leaves both stacks empty; no clearing pass is needed.
// in_ready is low while a character is worked or a result waits.
module infix_expression_evaluator import iee_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [1:0]         status
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_OPRD  = 4'd2;
	localparam logic [3:0] S_OPCHK = 4'd3;
	localparam logic [3:0] S_V1    = 4'd4;
	localparam logic [3:0] S_V2    = 4'd5;
	localparam logic [3:0] S_V3    = 4'd6;
	localparam logic [3:0] S_ALU   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_TOP   = 4'd9;
	localparam logic [3:0] S_TOPW  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	// Pop modes: what to do after popping an operator.
	localparam logic [1:0] M_OPER  = 2'd0;
	localparam logic [1:0] M_CLOSE = 2'd1;
	localparam logic [1:0] M_DRAIN = 2'd2;

	logic [3:0]       state_q;
	logic [1:0]       mode_q;
	logic [7:0]       ch_q;
	logic             last_q;
	logic [2:0]       newop_q;
	logic [2:0]       popop_q;
	logic [OpCw-1:0]  opc_q;
	logic [ValCw-1:0] valc_q;
	logic [1:0]       err_q;
	logic [31:0]      x_q;
	logic [31:0]      res_q;
	logic             out_valid_q;

	logic             op_we;
	logic [OpAw-1:0]  op_waddr;
	logic [2:0]       op_wdata;
	logic [OpAw-1:0]  op_raddr;
	logic [2:0]       op_rdata;
	logic             val_we;
	logic [ValAw-1:0] val_waddr;
	logic [31:0]      val_wdata;
	logic [ValAw-1:0] val_raddr;
	logic [31:0]      val_rdata;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	logic [2:0]       dec_op;
	logic             is_op;

	iee_ram #(.Width(3), .Depth(OpDepth)) u_op_ram (
		.clk(clk), .we(op_we), .waddr(op_waddr), .wdata(op_wdata),
		.raddr(op_raddr), .rdata(op_rdata)
	);

	iee_ram #(.Width(32), .Depth(ValDepth)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(val_raddr), .rdata(val_rdata)
	);

	iee_alu u_alu (.clk(clk), .arst_n(arst_n), .req(alu_req), .rsp(alu_rsp));

	always_comb begin
		is_op  = 1'b1;
		dec_op = OPC_ADD;
		case (ch_q)
			CH_ADD: dec_op = OPC_ADD;
			CH_SUB: dec_op = OPC_SUB;
			CH_MUL: dec_op = OPC_MUL;
			CH_DIV: dec_op = OPC_DIV;
			default: is_op = 1'b0;
		endcase
	end

	// Read addresses: top of operator stack; values at count-1 and count-2.
	assign op_raddr  = OpAw'(opc_q - OpCw'(1));
	assign val_raddr = (state_q == S_V1 || state_q == S_TOP) ?
		ValAw'(valc_q - ValCw'(1)) : ValAw'(valc_q - ValCw'(2));

	always_comb begin
		op_we     = 1'b0;
		op_waddr  = OpAw'(opc_q);
		op_wdata  = newop_q;
		val_we    = 1'b0;
		val_waddr = ValAw'(valc_q);
		val_wdata = {28'd0, ch_q[3:0]};
		alu_req.start = (state_q == S_V3);
		alu_req.op    = popop_q;
		alu_req.lhs   = val_rdata;
		alu_req.rhs   = x_q;
		if (state_q == S_DEC && err_q == ST_OK) begin
			if (ch_q >= CH_ZERO && ch_q <= CH_NINE && valc_q < ValCw'(ValDepth)) begin
				val_we = 1'b1;
			end
			if (ch_q == CH_LPAREN && opc_q < OpCw'(OpDepth)) begin
				op_we    = 1'b1;
				op_wdata = OPC_PAREN;
			end
		end
		if (state_q == S_OPCHK && mode_q == M_OPER && err_q == ST_OK
				&& !(opc_q != '0 && op_rdata != OPC_PAREN
				&& (prec_hi(op_rdata) || !prec_hi(newop_q)))
				&& opc_q < OpCw'(OpDepth)) begin
			op_we = 1'b1;
		end
		if (state_q == S_ALU && alu_rsp.done && !alu_rsp.divzero) begin
			val_we    = 1'b1;
			val_waddr = ValAw'(valc_q - ValCw'(2));
			val_wdata = alu_rsp.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_OPER;
			opc_q       <= '0;
			valc_q      <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ch_q    <= char_code;
						last_q  <= last_char;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					newop_q <= dec_op;
					state_q <= last_q ? S_OPRD : S_IDLE;
					mode_q  <= M_DRAIN;
					if (err_q == ST_OK) begin
						if (ch_q >= CH_ZERO && ch_q <= CH_NINE) begin
							if (valc_q < ValCw'(ValDepth)) valc_q <= valc_q + ValCw'(1);
							else err_q <= ST_OVERFLOW;
						end else if (ch_q == CH_LPAREN) begin
							if (opc_q < OpCw'(OpDepth)) opc_q <= opc_q + OpCw'(1);
							else err_q <= ST_OVERFLOW;
						end else if (ch_q == CH_RPAREN) begin
							mode_q  <= M_CLOSE;
							state_q <= S_OPRD;
						end else if (is_op) begin
							mode_q  <= M_OPER;
							state_q <= S_OPRD;
						end
					end
				end
				S_OPRD: begin
					state_q <= S_OPCHK;
				end
				S_OPCHK: begin
					popop_q <= op_rdata;
					case (mode_q)
						M_OPER: begin
							if (err_q != ST_OK) begin
								state_q <= last_q ? S_FIN : S_IDLE;
							end else if (opc_q != '0 && op_rdata != OPC_PAREN
									&& (prec_hi(op_rdata) || !prec_hi(newop_q))) begin
								opc_q   <= opc_q - OpCw'(1);
								state_q <= S_V1;
							end else begin
								if (opc_q < OpCw'(OpDepth)) opc_q <= opc_q + OpCw'(1);
								else err_q <= ST_OVERFLOW;
								state_q <= last_q ? S_OPRD : S_IDLE;
								mode_q  <= M_DRAIN;
							end
						end
						M_CLOSE: begin
							if (err_q != ST_OK) begin
								state_q <= last_q ? S_FIN : S_IDLE;
							end else if (opc_q == '0) begin
								err_q   <= ST_MALFORMED;
								state_q <= last_q ? S_FIN : S_IDLE;
							end else if (op_rdata == OPC_PAREN) begin
								opc_q   <= opc_q - OpCw'(1);
								state_q <= last_q ? S_OPRD : S_IDLE;
								mode_q  <= M_DRAIN;
							end else begin
								opc_q   <= opc_q - OpCw'(1);
								state_q <= S_V1;
							end
						end
						default: begin
							if (err_q != ST_OK || opc_q == '0) begin
								state_q <= S_FIN;
							end else if (op_rdata == OPC_PAREN) begin
								err_q   <= ST_MALFORMED;
								state_q <= S_FIN;
							end else begin
								opc_q   <= opc_q - OpCw'(1);
								state_q <= S_V1;
							end
						end
					endcase
				end
				S_V1: begin
					if (valc_q < ValCw'(2)) begin
						err_q   <= ST_MALFORMED;
						state_q <= S_OPRD;
					end else begin
						state_q <= S_V2;
					end
				end
				S_V2: begin
					x_q     <= val_rdata;
					state_q <= S_V3;
				end
				S_V3: begin
					state_q <= S_ALU;
				end
				S_ALU: begin
					if (alu_rsp.done) begin
						if (alu_rsp.divzero) err_q <= ST_DIVZERO;
						else valc_q <= valc_q - ValCw'(1);
						state_q <= S_OPRD;
					end
				end
				S_FIN: begin
					if (err_q == ST_OK && valc_q == '0) err_q <= ST_MALFORMED;
					state_q <= S_TOP;
				end
				S_TOP: begin
					state_q <= S_TOPW;
				end
				S_TOPW: begin
					res_q       <= (err_q == ST_OK) ? val_rdata : 32'd0;
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						opc_q       <= '0;
						valc_q      <= '0;
						err_q       <= ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign value     = res_q;
	assign status    = err_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	a_opc_range: assert property (@(posedge clk) disable iff (!arst_n)
		opc_q <= OpCw'(OpDepth)) else $error("operator count out of range");
	a_valc_range: assert property (@(posedge clk) disable iff (!arst_n)
		valc_q <= ValCw'(ValDepth)) else $error("value count out of range");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> opc_q == '0 && valc_q == '0)
		else $error("stacks not cleared after result");
`endif
endmodule

[tb/infix_expression_evaluator_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Infix expression evaluator testbench
// Streams directed and random expressions into the evaluator, predicts each
// result with a behavioral shunting-yard evaluator, and compares every
// result transfer field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module infix_expression_evaluator_tb;
	import iee_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         char_code;
	logic               last_char;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] value;
	logic [1:0]         status;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct {
		logic [31:0] val;
		logic [1:0]  st;
	} eval_result_t;

	char_item_t   pending_chars[$];
	eval_result_t expected_results[$];

	// Predictor state.
	logic [2:0]  pred_ops[OpDepth];
	int          pred_op_cnt;
	logic [31:0] pred_vals[ValDepth];
	int          pred_val_cnt;
	logic [1:0]  pred_err;

	int  fail_count;
	int  cycle_count;
	bit  stim_done;
	int  in_gap;
	int  out_gap;

	infix_expression_evaluator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_code(char_code),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value),
		.status   (status)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic void flag_error(input logic [1:0] code);
		if (pred_err == ST_OK)
			pred_err = code;
	endfunction

	function automatic void push_val(input logic [31:0] v);
		if (pred_val_cnt >= ValDepth)
			flag_error(ST_OVERFLOW);
		else begin
			pred_vals[pred_val_cnt] = v;
			pred_val_cnt++;
		end
	endfunction

	function automatic void push_oper(input logic [2:0] op);
		if (pred_op_cnt >= OpDepth)
			flag_error(ST_OVERFLOW);
		else begin
			pred_ops[pred_op_cnt] = op;
			pred_op_cnt++;
		end
	endfunction

	function automatic void reduce(input logic [2:0] op);
		logic [31:0] rhs;
		logic [31:0] lhs;
		logic [31:0] res;
		if (pred_err != ST_OK)
			return;
		if (pred_val_cnt < 2) begin
			flag_error(ST_MALFORMED);
			return;
		end
		rhs = pred_vals[pred_val_cnt - 1];
		lhs = pred_vals[pred_val_cnt - 2];
		pred_val_cnt -= 2;
		case (op)
			OPC_ADD: res = lhs + rhs;
			OPC_SUB: res = lhs - rhs;
			OPC_MUL: res = lhs * rhs;
			default: begin
				if (rhs == 32'd0) begin
					flag_error(ST_DIVZERO);
					return;
				end
				if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF)
					res = 32'h8000_0000;
				else
					res = $signed(lhs) / $signed(rhs);
			end
		endcase
		pred_vals[pred_val_cnt] = res;
		pred_val_cnt++;
	endfunction

	function automatic int rank(input logic [2:0] op);
		return (op == OPC_MUL || op == OPC_DIV) ? 2 : 1;
	endfunction

	function automatic void eval_char(input logic [7:0] ch, input logic last);
		logic [2:0]   op;
		logic [2:0]   top;
		bit           is_op;
		eval_result_t r;
		if (pred_err == ST_OK) begin
			is_op = 1'b0;
			case (ch)
				CH_ADD: begin op = OPC_ADD; is_op = 1'b1; end
				CH_SUB: begin op = OPC_SUB; is_op = 1'b1; end
				CH_MUL: begin op = OPC_MUL; is_op = 1'b1; end
				CH_DIV: begin op = OPC_DIV; is_op = 1'b1; end
				default: op = OPC_PAREN;
			endcase
			if (ch >= CH_ZERO && ch <= CH_NINE)
				push_val(32'(ch - CH_ZERO));
			else if (ch == CH_LPAREN)
				push_oper(OPC_PAREN);
			else if (ch == CH_RPAREN) begin
				while (pred_err == ST_OK) begin
					if (pred_op_cnt == 0) begin
						flag_error(ST_MALFORMED);
						break;
					end
					pred_op_cnt--;
					top = pred_ops[pred_op_cnt];
					if (top == OPC_PAREN)
						break;
					reduce(top);
				end
			end else if (is_op) begin
				while (pred_err == ST_OK && pred_op_cnt > 0) begin
					top = pred_ops[pred_op_cnt - 1];
					if (top == OPC_PAREN || rank(top) < rank(op))
						break;
					pred_op_cnt--;
					reduce(top);
				end
				if (pred_err == ST_OK)
					push_oper(op);
			end
		end
		if (!last)
			return;
		while (pred_err == ST_OK && pred_op_cnt > 0) begin
			pred_op_cnt--;
			top = pred_ops[pred_op_cnt];
			if (top == OPC_PAREN)
				flag_error(ST_MALFORMED);
			else
				reduce(top);
		end
		if (pred_err == ST_OK && pred_val_cnt == 0)
			flag_error(ST_MALFORMED);
		r.val = (pred_err == ST_OK) ? pred_vals[pred_val_cnt - 1] : 32'd0;
		r.st  = pred_err;
		expected_results.insert(expected_results.size(), r);
		pred_op_cnt  = 0;
		pred_val_cnt = 0;
		pred_err     = ST_OK;
	endfunction

	task automatic add_expr(input string s);
		char_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.ch   = s[i];
			it.last = (i == s.len() - 1);
			pending_chars.insert(pending_chars.size(), it);
		end
	endtask

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_oper();
		case ($urandom_range(0, 3))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	// The last stretch of the run has no idling on either side.
	function automatic bit quiet();
		return stim_done && pending_chars.size() < 150;
	endfunction

	// Well-formed expression with random content, nesting up to a few levels.
	function automatic string gen_expr(input int lvl);
		string s;
		int    terms;
		terms = $urandom_range(1, 4);
		s = "";
		for (int i = 0; i < terms; i++) begin
			if (i > 0)
				s = {s, string'(rand_oper())};
			if (lvl < 3 && $urandom_range(0, 3) == 0)
				s = {s, "(", gen_expr(lvl + 1), ")"};
			else
				s = {s, string'(rand_digit())};
		end
		return s;
	endfunction

	initial begin
		string s;
		char_item_t it;
		// Directed expressions: operators, precedence, parentheses, errors.
		add_expr("7");
		add_expr("1+2*3");
		add_expr("9-4-3");
		add_expr("8/2/2");
		add_expr("(1+2)*3");
		add_expr("0-7/2");
		add_expr("5/0");
		add_expr("+");
		add_expr(")");
		add_expr("(5");
		add_expr("34");
		add_expr("a1 +\xff2");
		// Empty expression: a lone ignored final character.
		it.ch = 8'h00; it.last = 1'b1; pending_chars.insert(pending_chars.size(), it);
		// Overflow of the value stack and of the operator stack.
		s = "";
		for (int i = 0; i < ValDepth + 1; i++) s = {s, "9"};
		add_expr(s);
		s = "";
		for (int i = 0; i < OpDepth + 1; i++) s = {s, "("};
		add_expr({s, "1"});
		// Products that wrap past 32 bits, two of them then divided by minus one.
		add_expr("(0-8)*8*8*8*8*8*8*8*8*8*8/(0-1)");
		add_expr("(0-2)*8*8*8*8*8*8*8*8*8*8*2/(0-1)");
		add_expr("9*9*9*9*9*9*9*9*9*9*9");
		// Random part: mostly well-formed expressions, some noise.
		while (pending_chars.size() < 1400) begin
			case ($urandom_range(0, 9))
				0: begin
					int n;
					n = $urandom_range(1, 8);
					for (int i = 0; i < n; i++) begin
						it.ch   = 8'($urandom_range(0, 255));
						it.last = (i == n - 1);
						pending_chars.insert(pending_chars.size(), it);
					end
				end
				1: begin
					int n;
					n = $urandom_range(1, 10);
					for (int i = 0; i < n; i++) begin
						case ($urandom_range(0, 3))
							0: it.ch = rand_oper();
							1: it.ch = ($urandom_range(0, 1) != 0) ? CH_LPAREN : CH_RPAREN;
							default: it.ch = rand_digit();
						endcase
						it.last = (i == n - 1);
						pending_chars.insert(pending_chars.size(), it);
					end
				end
				default: add_expr(gen_expr(0));
			endcase
		end
		stim_done = 1'b1;
	end

	initial begin
		fail_count  = 0;
		cycle_count = 0;
		pred_op_cnt = 0;
		pred_val_cnt = 0;
		pred_err    = ST_OK;
		in_valid    = 1'b0;
		char_code   = 8'd0;
		last_char   = 1'b0;
		out_ready   = 1'b0;
		in_gap      = 0;
		out_gap     = 0;
		arst_n      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: holds the item until its transfer, then may insert a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				eval_char(char_code, last_char);
				if (!quiet() && $urandom_range(0, 5) == 0)
					in_gap = $urandom_range(1, 12);
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (stim_done && pending_chars.size() > 0) begin
					char_item_t it;
					it = pending_chars.pop_front();
					in_valid  <= 1'b1;
					char_code <= it.ch;
					last_char <= it.last;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random stall bursts on the result side and the comparison.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				eval_result_t r;
				if (expected_results.size() == 0) begin
					$error("unexpected result value=%0d status=%0d", value, status);
					fail_count++;
				end else begin
					r = expected_results.pop_front();
					if (value !== r.val) begin
						$error("value expected %0d actual %0d", $signed(r.val), value);
						fail_count++;
					end
					if (status !== r.st) begin
						$error("status expected %0d actual %0d", r.st, status);
						fail_count++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!quiet() && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin
		wait (stim_done);
		while ((pending_chars.size() > 0 || in_valid || expected_results.size() > 0)
			&& cycle_count < 1000000)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (cycle_count >= 1000000) begin
			$display("TB_ERROR");
		end else if (fail_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end
endmodule
